@@ sv/sstc_pkg.sv @@
// Shared types, constants and codes for the sonar scan and track controller.
package sstc_pkg;

   localparam int unsigned MAX_ANGLE   = 180;
   localparam int unsigned ANGLE_W     = 8;
   localparam int unsigned DIST_W      = 13;
   localparam int unsigned CFG_DIST_W  = 12;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned SPEED_W     = 20;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned SCAN_STEP   = 2;
   localparam int unsigned TUNE_STEP   = 5;
   localparam int unsigned LOSS_STEP   = 15;
   localparam int unsigned SPEED_LIMIT = 400000;
   localparam int unsigned SPEED_SCALE = 1000;
   localparam int unsigned MIN_DT_MS   = 10;
   // |diff| * 1000 fits in 23 bits
   localparam int unsigned DIVIDEND_W  = 23;
   localparam int unsigned DIV_CNT_W   = 5;
   localparam int unsigned CENTER_ANGLE = (90 < MAX_ANGLE) ? 90 : MAX_ANGLE;

   // request item kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_REPLY = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;
   localparam logic [1:0] REQ_START = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_MEASURE = 2'd0;
   localparam logic [1:0] KIND_SCAN    = 2'd1;
   localparam logic [1:0] KIND_TRACK   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TUNE_INTERVAL = 3'd4;

   // scan/track phase of the ranger
   typedef enum logic [7:0] {
      PH_SCAN_IDLE  = 8'b0000_0001,
      PH_SCAN_WAIT  = 8'b0000_0010,
      PH_TRACK_IDLE = 8'b0000_0100,
      PH_CENTER     = 8'b0000_1000,
      PH_LEFT       = 8'b0001_0000,
      PH_RIGHT      = 8'b0010_0000,
      PH_LOSS_MINUS = 8'b0100_0000,
      PH_LOSS_PLUS  = 8'b1000_0000
   } phase_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } seq_state_type;

   typedef struct packed {
      logic take_item;
      logic eval;
      logic div_start;
      logic div_wait;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic need_speed;
      logic div_done;
   } status_type;

endpackage

@@ sv/sstc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the approach speed.
module sstc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [sstc_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [sstc_pkg::TIME_W-1:0]         divisor,
   output logic                                done,
   output logic [sstc_pkg::DIVIDEND_W-1:0]     quotient
);

   logic [sstc_pkg::TIME_W-1:0]     rem_ff, rem_in;
   logic [sstc_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [sstc_pkg::TIME_W-1:0]     dvs_ff, dvs_in;
   logic [sstc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [sstc_pkg::TIME_W:0]       trial;
   logic [sstc_pkg::TIME_W:0]       diff;

   assign trial = {rem_ff, quo_ff[sstc_pkg::DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (!diff[sstc_pkg::TIME_W]) begin
            rem_in = diff[sstc_pkg::TIME_W-1:0];
            quo_in = {quo_ff[sstc_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[sstc_pkg::TIME_W-1:0];
            quo_in = {quo_ff[sstc_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sstc_pkg::DIV_CNT_W'(sstc_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/sstc_datapath.sv @@
// Datapath: configuration, ranger state, step evaluation, speed and result register.
module sstc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sstc_pkg::cmd_type                     cmd,
   output sstc_pkg::status_type                  status,
   input  logic                                  csr_wr_en,
   input  logic [sstc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sstc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [1:0]                            req_type,
   input  logic [sstc_pkg::DIST_W-1:0]           req_range_reading,
   input  logic                                  req_no_echo,
   output logic [1:0]                            rsp_kind,
   output logic [sstc_pkg::ANGLE_W-1:0]          rsp_angle,
   output logic [sstc_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                  rsp_out_of_range,
   output logic signed [sstc_pkg::SPEED_W-1:0]   rsp_speed
);

   localparam int unsigned AW = sstc_pkg::ANGLE_W;
   localparam int unsigned DW = sstc_pkg::DIST_W;
   localparam int unsigned TW = sstc_pkg::TIME_W;

   // configuration
   logic [7:0]                      scan_period_ff;
   logic [sstc_pkg::CFG_DIST_W-1:0] lock_max_ff, lock_min_ff;
   logic [15:0]                     lost_timeout_ff, tune_interval_ff;

   // latched item
   logic [1:0]    it_type_ff;
   logic [DW-1:0] it_dist_ff;
   logic          it_no_echo_ff;

   // ranger state
   sstc_pkg::phase_type phase_ff, phase_in;
   logic          stopped_ff, stopped_in;
   logic          sweep_up_ff, sweep_up_in;
   logic [AW-1:0] cur_angle_ff, cur_angle_in;
   logic [AW-1:0] best_angle_ff, best_angle_in;
   logic [DW-1:0] last_dist_ff, last_dist_in;
   logic [DW-1:0] best_dist_ff, best_dist_in;
   logic [TW-1:0] now_ff, now_in;
   logic [TW-1:0] last_step_ff, last_step_in;
   logic [TW-1:0] last_tune_ff, last_tune_in;
   logic [TW-1:0] last_seen_ff, last_seen_in;
   logic [TW-1:0] last_report_ff, last_report_in;
   logic [TW-1:0] tune_start_ff, tune_start_in;

   // pending result
   logic          has_res;
   logic          need_spd;
   logic [1:0]    res_kind_ff, res_kind_in;
   logic [AW-1:0] res_angle_ff, res_angle_in;
   logic [DW-1:0] res_dist_ff, res_dist_in;
   logic          res_oor_ff, res_oor_in;
   logic signed [sstc_pkg::SPEED_W-1:0] res_speed_ff;
   logic          has_res_ff, need_spd_ff;
   logic          neg_ff, neg_in;
   logic [DW-1:0] mag_ff, mag_in;
   logic [TW-1:0] dt_ff, dt_in;

   // output register
   logic [1:0]    out_kind_ff;
   logic [AW-1:0] out_angle_ff;
   logic [DW-1:0] out_dist_ff;
   logic          out_oor_ff;
   logic signed [sstc_pkg::SPEED_W-1:0] out_speed_ff;

   // divider
   logic [sstc_pkg::DIVIDEND_W-1:0] dividend;
   logic [sstc_pkg::DIVIDEND_W-1:0] quotient;
   logic                            div_done;
   logic [sstc_pkg::DIVIDEND_W-1:0] q_sat;

   function automatic logic [AW-1:0] clamp_angle(input logic signed [AW+1:0] a);
      logic [AW-1:0] r;
      if (a < 0)
         r = '0;
      else if (a > (AW+2)'(sstc_pkg::MAX_ANGLE))
         r = AW'(sstc_pkg::MAX_ANGLE);
      else
         r = a[AW-1:0];
      return r;
   endfunction

   logic                    echo, valid, better;
   logic signed [AW+1:0]    c_s;
   logic [AW:0]             up_step;
   logic [AW:0]             dn_step;
   logic [TW-1:0]           now_inc;
   logic [TW-1:0]           dt_cur;
   logic [AW-1:0]           ang_m15, ang_p15, ang_m5, ang_p5;
   logic [AW-1:0]           trk_ang;
   logic [DW-1:0]           trk_dist;
   logic                    trk;

   assign echo    = !it_no_echo_ff;
   assign valid   = echo && (it_dist_ff >= DW'(lock_min_ff)) && (it_dist_ff <= DW'(lock_max_ff));
   assign better  = echo && (it_dist_ff >= DW'(lock_min_ff)) && (it_dist_ff < best_dist_ff);
   assign c_s     = $signed({2'b00, cur_angle_ff});
   assign ang_m15 = clamp_angle(c_s - (AW+2)'(sstc_pkg::LOSS_STEP));
   assign ang_p15 = clamp_angle(c_s + (AW+2)'(sstc_pkg::LOSS_STEP));
   assign ang_m5  = clamp_angle(c_s - (AW+2)'(sstc_pkg::TUNE_STEP));
   assign ang_p5  = clamp_angle(c_s + (AW+2)'(sstc_pkg::TUNE_STEP));
   assign up_step = {1'b0, cur_angle_ff} + (AW+1)'(sstc_pkg::SCAN_STEP);
   assign dn_step = {1'b0, cur_angle_ff} - (AW+1)'(sstc_pkg::SCAN_STEP);
   assign now_inc = now_ff + 1'b1;
   assign dt_cur  = tune_start_ff - last_report_ff;

   always_comb begin
      phase_in       = phase_ff;
      stopped_in     = stopped_ff;
      sweep_up_in    = sweep_up_ff;
      cur_angle_in   = cur_angle_ff;
      best_angle_in  = best_angle_ff;
      last_dist_in   = last_dist_ff;
      best_dist_in   = best_dist_ff;
      now_in         = now_ff;
      last_step_in   = last_step_ff;
      last_tune_in   = last_tune_ff;
      last_seen_in   = last_seen_ff;
      last_report_in = last_report_ff;
      tune_start_in  = tune_start_ff;
      has_res        = 1'b0;
      need_spd       = 1'b0;
      res_kind_in    = sstc_pkg::KIND_MEASURE;
      res_angle_in   = '0;
      res_dist_in    = '0;
      res_oor_in     = 1'b0;
      neg_in         = 1'b0;
      mag_in         = '0;
      dt_in          = dt_cur;
      trk            = 1'b0;
      trk_ang        = best_angle_ff;
      trk_dist       = it_dist_ff;

      case (it_type_ff)
         sstc_pkg::REQ_STOP: begin
            stopped_in = 1'b1;
            phase_in   = sstc_pkg::PH_SCAN_IDLE;
         end
         sstc_pkg::REQ_START: begin
            stopped_in = 1'b0;
         end
         sstc_pkg::REQ_TICK: begin
            now_in = now_inc;
            if (!stopped_ff) begin
               if (phase_ff == sstc_pkg::PH_SCAN_IDLE) begin
                  if ((now_inc - last_step_ff) >= TW'(scan_period_ff)) begin
                     if (sweep_up_ff) begin
                        if (up_step >= (AW+1)'(sstc_pkg::MAX_ANGLE)) begin
                           cur_angle_in = AW'(sstc_pkg::MAX_ANGLE);
                           sweep_up_in  = 1'b0;
                        end else begin
                           cur_angle_in = up_step[AW-1:0];
                        end
                     end else begin
                        if (cur_angle_ff <= AW'(sstc_pkg::SCAN_STEP)) begin
                           cur_angle_in = '0;
                           sweep_up_in  = 1'b1;
                        end else begin
                           cur_angle_in = dn_step[AW-1:0];
                        end
                     end
                     last_step_in  = now_inc;
                     best_angle_in = cur_angle_in;
                     phase_in      = sstc_pkg::PH_SCAN_WAIT;
                     has_res       = 1'b1;
                     res_angle_in  = cur_angle_in;
                  end
               end else if (phase_ff == sstc_pkg::PH_TRACK_IDLE) begin
                  if ((now_inc - last_tune_ff) >= TW'(tune_interval_ff)) begin
                     last_tune_in  = now_inc;
                     tune_start_in = now_inc;
                     best_angle_in = cur_angle_ff;
                     phase_in      = sstc_pkg::PH_CENTER;
                     has_res       = 1'b1;
                     res_angle_in  = cur_angle_ff;
                  end
               end
            end
         end
         sstc_pkg::REQ_REPLY: begin
            if (!stopped_ff) begin
               case (phase_ff)
                  sstc_pkg::PH_SCAN_WAIT: begin
                     has_res      = 1'b1;
                     res_kind_in  = sstc_pkg::KIND_SCAN;
                     res_angle_in = cur_angle_ff;
                     res_dist_in  = echo ? it_dist_ff : '0;
                     res_oor_in   = !echo;
                     if (valid) begin
                        last_seen_in   = now_ff;
                        last_tune_in   = now_ff;
                        last_report_in = now_ff;
                        last_dist_in   = it_dist_ff;
                        phase_in       = sstc_pkg::PH_TRACK_IDLE;
                     end else begin
                        phase_in = sstc_pkg::PH_SCAN_IDLE;
                     end
                  end
                  sstc_pkg::PH_CENTER: begin
                     has_res = 1'b1;
                     if (!valid) begin
                        res_angle_in  = ang_m15;
                        best_angle_in = ang_m15;
                        phase_in      = sstc_pkg::PH_LOSS_MINUS;
                     end else begin
                        best_dist_in  = it_dist_ff;
                        res_angle_in  = ang_m5;
                        best_angle_in = ang_m5;
                        phase_in      = sstc_pkg::PH_LEFT;
                     end
                  end
                  sstc_pkg::PH_LEFT: begin
                     // keep the left probe as best only if it came in closer
                     has_res      = 1'b1;
                     res_angle_in = ang_p5;
                     phase_in     = sstc_pkg::PH_RIGHT;
                     if (better)
                        best_dist_in = it_dist_ff;
                     else
                        best_angle_in = cur_angle_ff;
                  end
                  sstc_pkg::PH_RIGHT: begin
                     trk      = 1'b1;
                     trk_ang  = better ? ang_p5 : best_angle_ff;
                     trk_dist = better ? it_dist_ff : best_dist_ff;
                     best_dist_in  = trk_dist;
                     best_angle_in = trk_ang;
                  end
                  sstc_pkg::PH_LOSS_MINUS: begin
                     if (valid) begin
                        trk = 1'b1;
                     end else begin
                        has_res       = 1'b1;
                        res_angle_in  = ang_p15;
                        best_angle_in = ang_p15;
                        phase_in      = sstc_pkg::PH_LOSS_PLUS;
                     end
                  end
                  sstc_pkg::PH_LOSS_PLUS: begin
                     if (valid)
                        trk = 1'b1;
                     else if ((tune_start_ff - last_seen_ff) > TW'(lost_timeout_ff))
                        phase_in = sstc_pkg::PH_SCAN_IDLE;
                     else
                        phase_in = sstc_pkg::PH_TRACK_IDLE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      // track report: move to the chosen angle, stamp with the round start
      if (trk) begin
         has_res        = 1'b1;
         res_kind_in    = sstc_pkg::KIND_TRACK;
         res_angle_in   = trk_ang;
         res_dist_in    = trk_dist;
         cur_angle_in   = trk_ang;
         last_dist_in   = trk_dist;
         last_seen_in   = tune_start_ff;
         last_report_in = tune_start_ff;
         phase_in       = sstc_pkg::PH_TRACK_IDLE;
         need_spd       = dt_cur > TW'(sstc_pkg::MIN_DT_MS);
         neg_in         = trk_dist > last_dist_ff;
         mag_in         = neg_in ? (trk_dist - last_dist_ff) : (last_dist_ff - trk_dist);
      end
   end

   assign dividend = {{(sstc_pkg::DIVIDEND_W - DW){1'b0}}, mag_ff} *
                     sstc_pkg::DIVIDEND_W'(sstc_pkg::SPEED_SCALE);

   sstc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign q_sat = (quotient > sstc_pkg::DIVIDEND_W'(sstc_pkg::SPEED_LIMIT)) ?
                  sstc_pkg::DIVIDEND_W'(sstc_pkg::SPEED_LIMIT) : quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff   <= 8'd40;
         lock_max_ff      <= 12'd1000;
         lock_min_ff      <= 12'd70;
         lost_timeout_ff  <= 16'd1500;
         tune_interval_ff <= 16'd60;
         phase_ff         <= sstc_pkg::PH_SCAN_IDLE;
         stopped_ff       <= 1'b0;
         sweep_up_ff      <= 1'b1;
         cur_angle_ff     <= AW'(sstc_pkg::CENTER_ANGLE);
         best_angle_ff    <= '0;
         last_dist_ff     <= '0;
         best_dist_ff     <= '0;
         now_ff           <= '0;
         last_step_ff     <= '0;
         last_tune_ff     <= '0;
         last_seen_ff     <= '0;
         last_report_ff   <= '0;
         tune_start_ff    <= '0;
         has_res_ff       <= 1'b0;
         need_spd_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               sstc_pkg::CSR_SCAN_PERIOD:   scan_period_ff   <= csr_wdata[7:0];
               sstc_pkg::CSR_LOCK_MAX:      lock_max_ff      <= csr_wdata[11:0];
               sstc_pkg::CSR_LOCK_MIN:      lock_min_ff      <= csr_wdata[11:0];
               sstc_pkg::CSR_LOST_TIMEOUT:  lost_timeout_ff  <= csr_wdata;
               sstc_pkg::CSR_TUNE_INTERVAL: tune_interval_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.eval) begin
            phase_ff       <= phase_in;
            stopped_ff     <= stopped_in;
            sweep_up_ff    <= sweep_up_in;
            cur_angle_ff   <= cur_angle_in;
            best_angle_ff  <= best_angle_in;
            last_dist_ff   <= last_dist_in;
            best_dist_ff   <= best_dist_in;
            now_ff         <= now_in;
            last_step_ff   <= last_step_in;
            last_tune_ff   <= last_tune_in;
            last_seen_ff   <= last_seen_in;
            last_report_ff <= last_report_in;
            tune_start_ff  <= tune_start_in;
            has_res_ff     <= has_res;
            need_spd_ff    <= need_spd;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         it_type_ff    <= req_type;
         it_dist_ff    <= req_range_reading;
         it_no_echo_ff <= req_no_echo;
      end
      if (cmd.eval) begin
         res_kind_ff  <= res_kind_in;
         res_angle_ff <= res_angle_in;
         res_dist_ff  <= res_dist_in;
         res_oor_ff   <= res_oor_in;
         res_speed_ff <= '0;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         dt_ff        <= dt_in;
      end else if (cmd.div_wait && div_done) begin
         res_speed_ff <= neg_ff ? -$signed(sstc_pkg::SPEED_W'(q_sat)) :
                                  $signed(sstc_pkg::SPEED_W'(q_sat));
      end
      if (cmd.out_load) begin
         out_kind_ff  <= res_kind_ff;
         out_angle_ff <= res_angle_ff;
         out_dist_ff  <= res_dist_ff;
         out_oor_ff   <= res_oor_ff;
         out_speed_ff <= res_speed_ff;
      end
   end

   assign status.has_result = has_res_ff;
   assign status.need_speed = need_spd_ff;
   assign status.div_done   = div_done;

   assign rsp_kind         = out_kind_ff;
   assign rsp_angle        = out_angle_ff;
   assign rsp_distance     = out_dist_ff;
   assign rsp_out_of_range = out_oor_ff;
   assign rsp_speed        = out_speed_ff;

endmodule

@@ sv/sstc_ctrl.sv @@
// Sequencer: input handshake, step evaluation, speed division and output register valid.
module sstc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sstc_pkg::cmd_type     cmd,
   input  sstc_pkg::status_type  status
);

   sstc_pkg::seq_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != sstc_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         sstc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = sstc_pkg::ST_EVAL;
            end
         end
         sstc_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sstc_pkg::ST_LOAD;
         end
         sstc_pkg::ST_LOAD: begin
            // start the divider only for a track report with a usable interval
            if (status.need_speed) begin
               cmd.div_start = 1'b1;
               state_in      = sstc_pkg::ST_DIV;
            end else if (status.has_result) begin
               state_in = sstc_pkg::ST_EMIT;
            end else begin
               state_in = sstc_pkg::ST_IDLE;
            end
         end
         sstc_pkg::ST_DIV: begin
            cmd.div_wait = 1'b1;
            if (status.div_done)
               state_in = sstc_pkg::ST_EMIT;
         end
         sstc_pkg::ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sstc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sstc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sstc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/sonar_scan_track_controller.sv @@
// Top level of the sonar scan and track controller.
//
// Usage: items arrive on the req_ channel (valid/stall): a 1 ms tick, a
// measurement reply, a stop or a start event. Each item causes zero or one
// result on the rsp_ channel: a measure request, a scan report or a track
// report with approach speed. Configuration is written through the csr_
// port (write enable, index, data). The user must write it only while the
// block is idle; the block itself does not enforce this. Flow: an item is
// accepted in idle, evaluated in the next cycle and its result then passes
// the load and emit states into the output register, emit waiting while
// the output is stalled; a track report with a speed first waits in the
// divide state until the bit-serial divider flags done. One item is in
// flight at a time.
// Reset: synchronous, active high; registers return to their reset values,
// the beam sits at 90 degrees, the block is scanning and nothing is pending.
// Stall: a held result waits in the output register with its fields stable;
// the next item may be accepted meanwhile and stops at the output until the
// register is taken.
module sonar_scan_track_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [sstc_pkg::DIST_W-1:0]         req_range_reading,
   input  logic                                req_no_echo,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_kind,
   output logic [sstc_pkg::ANGLE_W-1:0]        rsp_angle,
   output logic [sstc_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                rsp_out_of_range,
   output logic signed [sstc_pkg::SPEED_W-1:0] rsp_speed,
   input  logic                                csr_wr_en,
   input  logic [sstc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sstc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // commands from the sequencer, status back from the datapath
   sstc_pkg::cmd_type    cmd;
   sstc_pkg::status_type status;

   sstc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   sstc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_range_reading (req_range_reading),
      .req_no_echo       (req_no_echo),
      .rsp_kind          (rsp_kind),
      .rsp_angle         (rsp_angle),
      .rsp_distance      (rsp_distance),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_speed         (rsp_speed)
   );

endmodule

@@ sv/sstc_checker.sv @@
// Port-level checks for the sonar scan and track controller, bound to the top level.
module sstc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [1:0]                          rsp_kind,
   input logic [sstc_pkg::ANGLE_W-1:0]        rsp_angle,
   input logic                                rsp_out_of_range,
   input logic signed [sstc_pkg::SPEED_W-1:0] rsp_speed
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == sstc_pkg::KIND_MEASURE || rsp_kind == sstc_pkg::KIND_SCAN ||
                     rsp_kind == sstc_pkg::KIND_TRACK))
      else $error("unknown result kind");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle <= sstc_pkg::ANGLE_W'(sstc_pkg::MAX_ANGLE))
      else $error("angle beyond sweep");

   a_speed_only_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != sstc_pkg::KIND_TRACK |-> rsp_speed == '0 &&
      (rsp_kind == sstc_pkg::KIND_SCAN || !rsp_out_of_range))
      else $error("speed or out of range flag on wrong kind");

endmodule

bind sonar_scan_track_controller sstc_checker u_sstc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_angle        (rsp_angle),
   .rsp_out_of_range (rsp_out_of_range),
   .rsp_speed        (rsp_speed)
);

@@ bench/sonar_scan_track_controller_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sonar scan and track controller.
module sonar_scan_track_controller_tb;

   // One result transaction as it appears on the rsp_ channel.
   typedef struct {
      logic [1:0]                   kind;
      logic [sstc_pkg::ANGLE_W-1:0] angle;
      logic [sstc_pkg::DIST_W-1:0]  distance;
      logic                         out_of_range;
      logic [sstc_pkg::SPEED_W-1:0] speed;
   } ranger_result_type;

   // Predictor of the ranger plus the queue of results it has promised.
   class ranger_scoreboard_type;
      logic [7:0]                      scan_period;
      logic [sstc_pkg::CFG_DIST_W-1:0] lock_max, lock_min;
      logic [15:0]                     lost_timeout, tune_interval;
      sstc_pkg::phase_type             phase;
      bit                              stopped, tracking, sweep_up;
      logic [sstc_pkg::ANGLE_W-1:0]    cur_angle, best_angle;
      logic [sstc_pkg::TIME_W-1:0]     now_ms, last_step_ms, last_tune_ms, last_seen_ms;
      logic [sstc_pkg::TIME_W-1:0]     last_report_ms, tune_start_ms;
      logic [sstc_pkg::DIST_W-1:0]     last_dist, best_dist;
      ranger_result_type               expected_q[$];
      int                              errors;

      function void reset_state();
         scan_period = 40; lock_max = 1000; lock_min = 70;
         lost_timeout = 1500; tune_interval = 60;
         phase = sstc_pkg::PH_SCAN_IDLE; stopped = 0; tracking = 0; sweep_up = 1;
         cur_angle = sstc_pkg::ANGLE_W'(sstc_pkg::CENTER_ANGLE); best_angle = 0;
         now_ms = 0; last_step_ms = 0; last_tune_ms = 0; last_seen_ms = 0;
         last_report_ms = 0; tune_start_ms = 0; last_dist = 0; best_dist = 0;
      endfunction

      function void write_reg(logic [sstc_pkg::CSR_IDX_W-1:0] idx,
                              logic [sstc_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            sstc_pkg::CSR_SCAN_PERIOD:   scan_period = v[7:0];
            sstc_pkg::CSR_LOCK_MAX:      lock_max = v[sstc_pkg::CFG_DIST_W-1:0];
            sstc_pkg::CSR_LOCK_MIN:      lock_min = v[sstc_pkg::CFG_DIST_W-1:0];
            sstc_pkg::CSR_LOST_TIMEOUT:  lost_timeout = v;
            sstc_pkg::CSR_TUNE_INTERVAL: tune_interval = v;
            default: ;
         endcase
      endfunction

      function logic [sstc_pkg::ANGLE_W-1:0] clamp(int a);
         if (a < 0) return 0;
         if (a > int'(sstc_pkg::MAX_ANGLE))
            return sstc_pkg::ANGLE_W'(sstc_pkg::MAX_ANGLE);
         return a[sstc_pkg::ANGLE_W-1:0];
      endfunction

      function void push(logic [1:0] kind, logic [sstc_pkg::ANGLE_W-1:0] ang,
                         logic [sstc_pkg::DIST_W-1:0] dst, logic oor,
                         logic [sstc_pkg::SPEED_W-1:0] spd);
         ranger_result_type r;
         r.kind = kind; r.angle = ang; r.distance = dst;
         r.out_of_range = oor; r.speed = spd;
         expected_q.push_back(r);
      endfunction

      // Measure request; the probed angle is remembered as best so far.
      function void probe(logic [sstc_pkg::ANGLE_W-1:0] ang, sstc_pkg::phase_type nxt);
         best_angle = ang;
         phase = nxt;
         push(sstc_pkg::KIND_MEASURE, ang, 0, 0, 0);
      endfunction

      function void report_track(logic [sstc_pkg::ANGLE_W-1:0] ang,
                                 logic [sstc_pkg::DIST_W-1:0] dst);
         logic [sstc_pkg::TIME_W-1:0] dt;
         longint spd;
         dt = tune_start_ms - last_report_ms;
         spd = 0;
         if (dt > sstc_pkg::MIN_DT_MS) begin
            spd = (longint'(last_dist) - longint'(dst)) * longint'(sstc_pkg::SPEED_SCALE)
                  / longint'(dt);
            if (spd > longint'(sstc_pkg::SPEED_LIMIT)) spd = sstc_pkg::SPEED_LIMIT;
            if (spd < -longint'(sstc_pkg::SPEED_LIMIT)) spd = -longint'(sstc_pkg::SPEED_LIMIT);
         end
         cur_angle = ang;
         last_dist = dst;
         last_seen_ms = tune_start_ms;
         last_report_ms = tune_start_ms;
         phase = sstc_pkg::PH_TRACK_IDLE;
         push(sstc_pkg::KIND_TRACK, ang, dst, 0, spd[sstc_pkg::SPEED_W-1:0]);
      endfunction

      function void note_item(logic [1:0] typ, logic [sstc_pkg::DIST_W-1:0] d, logic ne);
         bit echo, ok, closer;
         int c;
         logic [sstc_pkg::ANGLE_W-1:0] ang;
         echo = !ne;
         ok = echo && d >= lock_min && d <= lock_max;
         closer = echo && d >= lock_min && d < best_dist;
         c = cur_angle;
         case (typ)
            sstc_pkg::REQ_STOP: begin
               stopped = 1; tracking = 0; phase = sstc_pkg::PH_SCAN_IDLE;
            end
            sstc_pkg::REQ_START: stopped = 0;
            sstc_pkg::REQ_TICK: begin
               now_ms = now_ms + 1;
               if (!stopped && phase == sstc_pkg::PH_SCAN_IDLE &&
                   now_ms - last_step_ms >= scan_period) begin
                  if (sweep_up) begin
                     c += sstc_pkg::SCAN_STEP;
                     if (c >= int'(sstc_pkg::MAX_ANGLE)) begin
                        c = sstc_pkg::MAX_ANGLE; sweep_up = 0;
                     end
                  end else begin
                     c -= sstc_pkg::SCAN_STEP;
                     if (c <= 0) begin
                        c = 0; sweep_up = 1;
                     end
                  end
                  cur_angle = c[sstc_pkg::ANGLE_W-1:0];
                  last_step_ms = now_ms;
                  probe(cur_angle, sstc_pkg::PH_SCAN_WAIT);
               end else if (!stopped && phase == sstc_pkg::PH_TRACK_IDLE &&
                            now_ms - last_tune_ms >= tune_interval) begin
                  last_tune_ms = now_ms;
                  tune_start_ms = now_ms;
                  probe(cur_angle, sstc_pkg::PH_CENTER);
               end
            end
            default: if (!stopped) begin
               case (phase)
                  sstc_pkg::PH_SCAN_WAIT: begin
                     push(sstc_pkg::KIND_SCAN, cur_angle, echo ? d : 0, !echo, 0);
                     if (ok) begin
                        tracking = 1;
                        last_seen_ms = now_ms; last_tune_ms = now_ms;
                        last_report_ms = now_ms; last_dist = d;
                        phase = sstc_pkg::PH_TRACK_IDLE;
                     end else
                        phase = sstc_pkg::PH_SCAN_IDLE;
                  end
                  sstc_pkg::PH_CENTER: begin
                     if (!ok)
                        probe(clamp(c - int'(sstc_pkg::LOSS_STEP)), sstc_pkg::PH_LOSS_MINUS);
                     else begin
                        best_dist = d;
                        probe(clamp(c - int'(sstc_pkg::TUNE_STEP)), sstc_pkg::PH_LEFT);
                     end
                  end
                  sstc_pkg::PH_LEFT: begin
                     // a closer left reading keeps the left angle as best
                     ang = closer ? best_angle : cur_angle;
                     if (closer) best_dist = d;
                     probe(clamp(c + int'(sstc_pkg::TUNE_STEP)), sstc_pkg::PH_RIGHT);
                     best_angle = ang;
                  end
                  sstc_pkg::PH_RIGHT: begin
                     ang = best_angle;
                     if (closer) begin
                        best_dist = d;
                        ang = clamp(c + int'(sstc_pkg::TUNE_STEP));
                     end
                     best_angle = ang;
                     report_track(ang, best_dist);
                  end
                  sstc_pkg::PH_LOSS_MINUS: begin
                     if (ok) report_track(best_angle, d);
                     else probe(clamp(c + int'(sstc_pkg::LOSS_STEP)), sstc_pkg::PH_LOSS_PLUS);
                  end
                  sstc_pkg::PH_LOSS_PLUS: begin
                     if (ok) report_track(best_angle, d);
                     else if (tune_start_ms - last_seen_ms > lost_timeout) begin
                        tracking = 0; phase = sstc_pkg::PH_SCAN_IDLE;
                     end else
                        phase = sstc_pkg::PH_TRACK_IDLE;
                  end
                  default: ;
               endcase
            end
         endcase
      endfunction

      function void check_result(ranger_result_type got);
         ranger_result_type exp_r;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: kind %0d angle %0d", got.kind, got.angle);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.kind !== exp_r.kind) begin
            $error("kind expected %0d actual %0d", exp_r.kind, got.kind); errors++;
         end
         if (got.angle !== exp_r.angle) begin
            $error("angle expected %0d actual %0d", exp_r.angle, got.angle); errors++;
         end
         if (got.distance !== exp_r.distance) begin
            $error("distance expected %0d actual %0d", exp_r.distance, got.distance);
            errors++;
         end
         if (got.out_of_range !== exp_r.out_of_range) begin
            $error("out_of_range expected %0d actual %0d", exp_r.out_of_range,
                   got.out_of_range);
            errors++;
         end
         if (got.speed !== exp_r.speed) begin
            $error("speed expected %0d actual %0d", $signed(exp_r.speed),
                   $signed(got.speed));
            errors++;
         end
      endfunction
   endclass

   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 5000;  // cycles with no transaction at all

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_stall;
   logic [1:0]                          req_type = sstc_pkg::REQ_TICK;
   logic [sstc_pkg::DIST_W-1:0]         req_range_reading = 0;
   logic                                req_no_echo = 0;
   logic                                rsp_valid;
   logic                                rsp_stall = 0;
   logic [1:0]                          rsp_kind;
   logic [sstc_pkg::ANGLE_W-1:0]        rsp_angle;
   logic [sstc_pkg::DIST_W-1:0]         rsp_distance;
   logic                                rsp_out_of_range;
   logic signed [sstc_pkg::SPEED_W-1:0] rsp_speed;
   logic                                csr_wr_en = 0;
   logic [sstc_pkg::CSR_IDX_W-1:0]      csr_index = sstc_pkg::CSR_SCAN_PERIOD;
   logic [sstc_pkg::CSR_DATA_W-1:0]     csr_wdata = 0;

   ranger_scoreboard_type ranger_sb = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   sonar_scan_track_controller DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Receiver: stall at random, resampled each falling edge.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      ranger_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_kind; got.angle = rsp_angle; got.distance = rsp_distance;
         got.out_of_range = rsp_out_of_range; got.speed = rsp_speed;
         ranger_sb.check_result(got);
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Drive one input transaction; entered and left at a falling edge.
   task automatic send_item(logic [1:0] typ, logic [sstc_pkg::DIST_W-1:0] d, logic ne);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= typ;
      req_range_reading <= d;
      req_no_echo <= ne;
      do @(posedge clock); while (req_stall);
      ranger_sb.note_item(typ, d, ne);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [sstc_pkg::CSR_IDX_W-1:0] idx,
                            logic [sstc_pkg::CSR_DATA_W-1:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      ranger_sb.write_reg(idx, v);
      @(negedge clock);
   endtask

   // Hold off until every expected result is in and the block has settled.
   task automatic drain();
      req_valid <= 0;
      while (ranger_sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_regs(int period, int lmax, int lmin, int lost, int tune);
      write_csr(sstc_pkg::CSR_SCAN_PERIOD, sstc_pkg::CSR_DATA_W'(period));
      write_csr(sstc_pkg::CSR_LOCK_MAX, sstc_pkg::CSR_DATA_W'(lmax));
      write_csr(sstc_pkg::CSR_LOCK_MIN, sstc_pkg::CSR_DATA_W'(lmin));
      write_csr(sstc_pkg::CSR_LOST_TIMEOUT, sstc_pkg::CSR_DATA_W'(lost));
      write_csr(sstc_pkg::CSR_TUNE_INTERVAL, sstc_pkg::CSR_DATA_W'(tune));
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   // Random traffic: mostly ticks, with replies to outstanding requests
   // carrying readings biased toward the lock window.
   task automatic random_items(int count);
      logic [1:0]                  typ;
      logic [sstc_pkg::DIST_W-1:0] d;
      logic                        ne;
      int                          roll;
      repeat (count) begin
         roll = $urandom_range(99);
         ne = ($urandom_range(99) < 15);
         if (ranger_sb.lock_min <= ranger_sb.lock_max && $urandom_range(99) < 70)
            d = $urandom_range(ranger_sb.lock_max, ranger_sb.lock_min);
         else
            d = $urandom_range(6000, 0);
         if (ranger_sb.stopped)
            typ = (roll < 60) ? sstc_pkg::REQ_START :
                  (roll < 80) ? sstc_pkg::REQ_TICK : sstc_pkg::REQ_REPLY;
         else if (ranger_sb.phase != sstc_pkg::PH_SCAN_IDLE &&
                  ranger_sb.phase != sstc_pkg::PH_TRACK_IDLE)
            typ = (roll < 60) ? sstc_pkg::REQ_REPLY : (roll < 96) ? sstc_pkg::REQ_TICK :
                  (roll < 98) ? sstc_pkg::REQ_STOP : sstc_pkg::REQ_START;
         else
            typ = (roll < 93) ? sstc_pkg::REQ_TICK : (roll < 96) ? sstc_pkg::REQ_REPLY :
                  (roll < 98) ? sstc_pkg::REQ_STOP : sstc_pkg::REQ_START;
         send_item(typ, d, ne);
      end
   endtask

   initial begin
      ranger_sb.reset_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: scan step, lock, center miss and both loss probes,
      // full fine-tune round with closer side readings, stop and start.
      send_idle_pct = 30; stall_pct = 53;
      program_regs(20, 4000, 0, 0, 0);
      repeat (20) send_item(sstc_pkg::REQ_TICK, 0, 0);
      send_item(sstc_pkg::REQ_REPLY, 4000, 0);       // scan report, locks
      send_item(sstc_pkg::REQ_TICK, 0, 0);           // center probe
      send_item(sstc_pkg::REQ_REPLY, 6000, 0);       // too far: minus probe
      send_item(sstc_pkg::REQ_REPLY, 8191, 1);       // no echo: plus probe
      send_item(sstc_pkg::REQ_REPLY, 0, 0);          // found again
      send_item(sstc_pkg::REQ_TICK, 0, 0);
      send_item(sstc_pkg::REQ_REPLY, 3000, 0);       // center hit
      send_item(sstc_pkg::REQ_REPLY, 100, 0);        // left is closer
      send_item(sstc_pkg::REQ_REPLY, 50, 0);         // right is closer still
      send_item(sstc_pkg::REQ_STOP, 0, 0);
      send_item(sstc_pkg::REQ_TICK, 0, 0);
      send_item(sstc_pkg::REQ_REPLY, 500, 0);        // ignored while stopped
      send_item(sstc_pkg::REQ_START, 0, 0);
      send_item(sstc_pkg::REQ_START, 0, 0);          // start when already running
      send_item(sstc_pkg::REQ_REPLY, 500, 1);        // stray reply, no request out
      random_items(300);

      drain();
      send_idle_pct = 53; stall_pct = 30;
      program_regs(40, 1000, 70, 1500, 60);
      random_items(300);

      drain();
      send_idle_pct = 0; stall_pct = 0;
      program_regs(200, 70, 4000, 65535, 65535);
      random_items(300);

      drain();
      program_regs(25, 3000, 100, 200, 15);
      random_items(300);

      drain();
      if (ranger_sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
